### hdl/text_console_cell_writer_unit_assert.svh
// ----------------------------------------------------------------------------
// text console cell writer assertion macros
// shared concurrent assertion forms, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define TCW_ASSERT_CYC(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, stays active through reset
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console cell writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // stream payload widths
    localparam int FUNC_W     = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int CELL_W     = 12;

    // command codes carried in tuser
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_PUT    = 2'd0;
    localparam t_func FUNC_CLEAR  = 2'd1;
    localparam t_func FUNC_SETCUR = 2'd2;
    localparam t_func FUNC_READ   = 2'd3;

    // character codes
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [3:0] RESET_COLOR = 4'hF;

    typedef struct packed {
        logic [3:0] color;
        logic [7:0] ch;
    } t_cell;

endpackage

### hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// text console engine over a character-cell store held in one block ram
// ----------------------------------------------------------------------------
// usage:
//   slave stream (i_s_*) takes one command per transaction: tuser is the
//   command (put character, clear screen, set cursor, read cell), tdata the
//   character and the column/row arguments.
//   master stream (o_m_*) returns exactly one result per command: cursor
//   column, row and linear offset, the scroll flag and the read cell.
//   config channel (i_cfg_*) sets the text color; always ready, write only
//   while no command is in flight.
// sequencing:
//   put character, set cursor and read cell run ST_EXEC then ST_DONE into the
//   output register; the next command is accepted only back in ST_IDLE.
//   clear screen adds a ST_FILL pass over every cell, a put character that
//   scrolls a ST_SCROLL pass and a last-row ST_FILL, paced by the one ram write port.
// reset:
//   cursor goes to 0,0, color to 0xF; a clearing pass then writes every
//   cell (COLUMNS*ROWS, 2000 by default) to a space in color 0xF, during
//   which o_s_tready stays low. config writes are taken meanwhile.
// stall:
//   the result sits in the output register while the next command is
//   accepted; that command completes only once the register is free.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: char_code[7:0], col[14:8], row[19:15], zero fill
    input  logic [tcw_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: func[1:0]
    input  logic [tcw_pkg::FUNC_W-1:0]    i_s_tuser,
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
    //        scrolled[23], cell_char[31:24], cell_color[35:32], zero fill
    output logic [tcw_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // text color register
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [3:0]                    i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CCW   = $clog2(COLUMNS);            // cursor column
    localparam int RW    = $clog2(ROWS);               // cursor row
    localparam int CW    = $clog2(COLUMNS + TAB_STEP); // column before wrap
    localparam int RXW   = $clog2(ROWS + 1);           // row before scroll

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_START = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_IDX   = AW'(CELLS - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]     r_state, n_state;
    logic [AW-1:0]  r_idx, n_idx;
    logic           r_init, n_init;
    logic [CCW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0]  r_cur_row, n_cur_row;
    logic           r_scrolled, n_scrolled;
    logic           r_m_valid, n_m_valid;
    logic [3:0]     r_text_color;

    // captured command
    t_func          r_func;
    logic [7:0]     r_char;
    logic [6:0]     r_col_in;
    logic [4:0]     r_row_in;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    // cell ram port
    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    t_cell          ram_wr_data;
    logic           ram_rd_en;
    logic [AW-1:0]  ram_rd_addr;
    t_cell          ram_rd_data;

    // put character decode
    logic [CW-1:0]  pc_col;
    logic [RXW-1:0] pc_row;
    logic           pc_wr;
    logic [CCW-1:0] pc_wcol;
    logic [7:0]     pc_wchar;
    logic           pc_scroll;

    logic [CCW-1:0] clamp_col;
    logic [RW-1:0]  clamp_row;
    logic [RW-1:0]  addr_row;
    logic [CCW-1:0] addr_col;
    logic [AW-1:0]  cell_addr;
    logic [AW-1:0]  cur_offset;
    logic [3:0]     fill_color;
    t_cell          out_cell;

    logic s_xact;
    logic m_load;

    assign s_xact      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_tdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next cursor for put character: edit, then column wrap, then scroll
    always_comb begin
        pc_col    = CW'(r_cur_col);
        pc_row    = RXW'(r_cur_row);
        pc_wr     = 1'b0;
        pc_wcol   = r_cur_col;
        pc_wchar  = r_char;
        pc_scroll = 1'b0;
        if (r_char == CH_BS) begin
            if (r_cur_col != '0) begin
                pc_col   = pc_col - 1'b1;
                pc_wcol  = r_cur_col - 1'b1;
                pc_wr    = 1'b1;
                pc_wchar = SPACE_CHAR;
            end
        end else if (r_char == CH_TAB) begin
            pc_col = pc_col + CW'(TAB_STEP);
        end else if (r_char == CH_LF) begin
            pc_col = '0;
            pc_row = pc_row + 1'b1;
        end else if (r_char >= SPACE_CHAR) begin
            pc_wr  = 1'b1;
            pc_col = pc_col + 1'b1;
        end
        if (pc_col >= CW'(COLUMNS)) begin
            pc_col = '0;
            pc_row = pc_row + 1'b1;
        end
        if (pc_row >= RXW'(ROWS)) begin
            pc_scroll = 1'b1;
            pc_row    = RXW'(ROWS - 1);
        end
    end

    // out-of-range coordinates pin to the last column / row
    assign clamp_col = (r_col_in >= COLUMNS) ? CCW'(COLUMNS - 1) : CCW'(r_col_in);
    assign clamp_row = (r_row_in >= ROWS) ? RW'(ROWS - 1) : RW'(r_row_in);

    assign addr_row   = (r_func == FUNC_READ) ? clamp_row : r_cur_row;
    assign addr_col   = (r_func == FUNC_READ) ? clamp_col : pc_wcol;
    assign cell_addr  = AW'(addr_row) * COLS_A + AW'(addr_col);
    assign cur_offset = AW'(r_cur_row) * COLS_A + AW'(r_cur_col);

    // reset pass always blanks in the reset color
    assign fill_color = r_init ? RESET_COLOR : r_text_color;
    assign out_cell   = (r_func == FUNC_READ) ? ram_rd_data : t_cell'('0);
    assign m_load     = (r_state == ST_DONE) && (!r_m_valid || i_m_tready);

    // sequencer and ram port control
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_init      = r_init;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_scrolled  = r_scrolled;
        n_m_valid   = r_m_valid;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cell_addr;
        ram_wr_data = '{color: r_text_color, ch: pc_wchar};
        ram_rd_en   = 1'b0;
        ram_rd_addr = cell_addr;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_xact) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_scrolled = 1'b0;
                n_state    = ST_DONE;
                unique case (r_func)
                    FUNC_PUT: begin
                        ram_wr_en  = pc_wr;
                        n_cur_col  = CCW'(pc_col);
                        n_cur_row  = RW'(pc_row);
                        n_scrolled = pc_scroll;
                        if (pc_scroll) begin
                            n_idx   = '0;
                            n_state = ST_SCROLL;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_cur_col = '0;
                        n_cur_row = '0;
                        n_idx     = '0;
                        n_state   = ST_FILL;
                    end
                    FUNC_SETCUR: begin
                        n_cur_col = clamp_col;
                        n_cur_row = clamp_row;
                    end
                    FUNC_READ: begin
                        ram_rd_en = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCROLL: begin
                // read one row ahead, write back the cell read last cycle
                ram_rd_en   = (r_idx < LAST_START);
                ram_rd_addr = r_idx + COLS_A;
                ram_wr_en   = (r_idx != '0);
                ram_wr_addr = r_idx - 1'b1;
                ram_wr_data = ram_rd_data;
                if (r_idx == LAST_START) begin
                    n_state = ST_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx;
                ram_wr_data = '{color: fill_color, ch: SPACE_CHAR};
                if (r_idx == LAST_IDX) begin
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (m_load) begin
                    n_m_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_idx        <= '0;
            r_init       <= 1'b1;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_scrolled   <= 1'b0;
            r_m_valid    <= 1'b0;
            r_text_color <= RESET_COLOR;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_init     <= n_init;
            r_cur_col  <= n_cur_col;
            r_cur_row  <= n_cur_row;
            r_scrolled <= n_scrolled;
            r_m_valid  <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_text_color <= i_cfg_data;
            end
        end
    end

    // command capture and result register
    always_ff @(posedge i_clk) begin
        if (s_xact) begin
            r_func   <= i_s_tuser;
            r_char   <= i_s_tdata[7:0];
            r_col_in <= i_s_tdata[14:8];
            r_row_in <= i_s_tdata[19:15];
        end
        if (m_load) begin
            r_m_tdata <= {4'b0000, out_cell.color, out_cell.ch, r_scrolled,
                          11'(cur_offset), 5'(r_cur_row), 7'(r_cur_col)};
        end
    end

endmodule

### hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level assertions for the text console cell writer, bound to the top
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_unit_assert.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [tcw_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic [tcw_pkg::FUNC_W-1:0]     i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [tcw_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [3:0]                     i_cfg_data
);

    import tcw_pkg::*;

    // after reset no result is pending and the clearing pass blocks commands
    `TCW_ASSERT_NXT(a_reset_quiet, !i_rst_n, !o_m_tvalid && !o_s_tready, "not quiet after reset")

    // a stalled result holds
    `TCW_ASSERT_NXT(a_result_hold, i_rst_n && o_m_tvalid && !i_m_tready, !i_rst_n || (o_m_tvalid && $stable(o_m_tdata)), "result dropped or changed under stall")

    // reported offset matches reported cursor
    `TCW_ASSERT_CYC(a_offset, o_m_tvalid && (COLUMNS <= 128) && (ROWS <= 32), o_m_tdata[22:12] == 11'(o_m_tdata[11:7] * COLUMNS + o_m_tdata[6:0]), "cursor offset mismatch")

    // a scroll leaves the cursor on the last row and reads no cell
    `TCW_ASSERT_CYC(a_scroll_row, o_m_tvalid && o_m_tdata[23], (o_m_tdata[11:7] == 5'(ROWS - 1)) && (o_m_tdata[35:24] == '0), "bad result after scroll")

endmodule

bind text_console_cell_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

### dv/tb_text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_unit
// self-checking bench for the text console cell writer: commands go in on the
// slave stream, each accepted transaction is run through a local model of the
// cell store and cursor, and every result transaction is compared field by
// field with the oldest expected one, under random stalls on both sides and
// several text color settings
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_unit;
    import tcw_pkg::*;

    // block geometry, default parameters of the block
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STEP   = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // run shape
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int TAIL_CYCLES  = 2 * CELL_COUNT + 100;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int REPORT_LIMIT = 10;

    // one command as carried on the slave stream
    typedef struct packed {
        t_func      func;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
    } console_cmd_t;

    // one result, packed so that it lines up with o_m_tdata[35:0]
    typedef struct packed {
        logic [3:0]  cell_color;
        logic [7:0]  cell_char;
        logic        scrolled;
        logic [10:0] offset;
        logic [4:0]  row;
        logic [6:0]  col;
    } console_result_t;

    // dut ports
    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata   = '0;
    logic [FUNC_W-1:0]      i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [3:0]             i_cfg_data  = '0;

    // model of the cell store, cursor and color register
    t_cell      screen_model [CELL_COUNT];
    int         cursor_col_model;
    int         cursor_row_model;
    logic [3:0] text_color_model;

    // commands waiting for the driver, results waiting for the block
    console_cmd_t    pending_cmds[$];
    console_result_t results_due[$];
    console_cmd_t    cmd_on_bus;

    int  cmds_queued    = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  s_fire         = 1'b0;
    bit  steady         = 1'b0;
    int  send_gap       = 0;
    int  ready_hold     = 0;

    text_console_cell_writer_unit #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // model of the block: applies one command and returns its result
    // ------------------------------------------------------------------------
    function automatic console_result_t run_console_cmd(console_cmd_t cmd);
        console_result_t res;
        int              c;
        int              r;
        int              i;
        res = '0;
        case (cmd.func)
            FUNC_PUT: begin
                if (cmd.ch == CH_BS) begin
                    // backspace blanks the cell it steps back onto, not at column 0
                    if (cursor_col_model != 0) begin
                        cursor_col_model--;
                        screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                            {text_color_model, SPACE_CHAR};
                    end
                end else if (cmd.ch == CH_TAB) begin
                    cursor_col_model += TAB_STEP;
                end else if (cmd.ch == CH_LF) begin
                    cursor_col_model = 0;
                    cursor_row_model++;
                end else if (cmd.ch >= SPACE_CHAR) begin
                    // printable, high bytes included
                    screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                        {text_color_model, cmd.ch};
                    cursor_col_model++;
                end
                // remaining control bytes leave everything alone
                if (cursor_col_model >= COLUMNS) begin
                    cursor_col_model = 0;
                    cursor_row_model++;
                end
                if (cursor_row_model >= ROWS) begin
                    // scroll up one row, new last row blank in the current color
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_model[i] = {text_color_model, SPACE_CHAR};
                    cursor_row_model = ROWS - 1;
                    res.scrolled     = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++)
                    screen_model[i] = {text_color_model, SPACE_CHAR};
                cursor_col_model = 0;
                cursor_row_model = 0;
            end
            FUNC_SETCUR: begin
                cursor_col_model = (cmd.col >= COLUMNS) ? COLUMNS - 1 : int'(cmd.col);
                cursor_row_model = (cmd.row >= ROWS) ? ROWS - 1 : int'(cmd.row);
            end
            default: begin
                // read cell, coordinates clamped, cursor untouched
                c = (cmd.col >= COLUMNS) ? COLUMNS - 1 : int'(cmd.col);
                r = (cmd.row >= ROWS) ? ROWS - 1 : int'(cmd.row);
                res.cell_char  = screen_model[r * COLUMNS + c].ch;
                res.cell_color = screen_model[r * COLUMNS + c].color;
            end
        endcase
        res.col    = cursor_col_model[6:0];
        res.row    = cursor_row_model[4:0];
        res.offset = 11'(cursor_row_model * COLUMNS + cursor_col_model);
        return res;
    endfunction

    // idle length: mostly none, some short, a few long, none in a steady phase
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // column and row arguments: mostly on screen, some beyond to reach clamping
    function automatic logic [6:0] draw_col();
        if ($urandom_range(0, 99) < 85)
            return 7'($urandom_range(0, COLUMNS - 1));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [4:0] draw_row();
        if ($urandom_range(0, 99) < 85)
            return 5'($urandom_range(0, ROWS - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    // put character bytes weighted toward the cases with their own handling
    function automatic logic [7:0] draw_char();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)
            return CH_BS;
        if (p < 14)
            return CH_TAB;
        if (p < 20)
            return CH_LF;
        if (p < 25)
            return 8'($urandom_range(0, 31));
        return 8'($urandom_range(32, 255));
    endfunction

    task automatic queue_cmd(t_func func, logic [7:0] ch, logic [6:0] col, logic [4:0] row);
        console_cmd_t cmd;
        cmd.func = func;
        cmd.ch   = ch;
        cmd.col  = col;
        cmd.row  = row;
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endtask

    // block idle: every queued command sent and every result back
    task automatic wait_for_drain();
        while (pending_cmds.size() != 0 || results_seen < cmds_queued)
            @(negedge i_clk);
    endtask

    function automatic void report_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // command driver: presents the next pending command after a random gap
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || s_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cmd_on_bus  = pending_cmds.pop_front();
                i_s_tdata  <= {4'b0, cmd_on_bus.row, cmd_on_bus.col, cmd_on_bus.ch};
                i_s_tuser  <= cmd_on_bus.func;
                i_s_tvalid <= 1'b1;
                send_gap    = draw_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            ready_hold  = draw_gap();
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on accepted commands, checks accepted results
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        console_result_t got;
        console_result_t want;
        s_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            text_color_model = i_cfg_data;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            results_due.push_back(run_console_cmd(cmd_on_bus));
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            got = o_m_tdata[35:0];
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result transaction with nothing expected: %h", o_m_tdata);
            end else begin
                want = results_due.pop_front();
                report_field("cursor_col", want.col, got.col);
                report_field("cursor_row", want.row, got.row);
                report_field("cursor_offset", want.offset, got.offset);
                report_field("scrolled", want.scrolled, got.scrolled);
                report_field("cell_char", want.cell_char, got.cell_char);
                report_field("cell_color", want.cell_color, got.cell_color);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int         ph;
        int         n;
        int         p;
        logic [3:0] color_pick [PHASE_COUNT];

        // model state after reset
        for (n = 0; n < CELL_COUNT; n++)
            screen_model[n] = {RESET_COLOR, SPACE_CHAR};
        cursor_col_model = 0;
        cursor_row_model = 0;
        text_color_model = RESET_COLOR;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset color
        queue_cmd(FUNC_READ, 8'h00, 7'd0, 5'd0);          // store cleared by reset
        queue_cmd(FUNC_PUT, 8'h41, 7'd127, 5'd31);        // printable, unused args all ones
        queue_cmd(FUNC_PUT, 8'h00, 7'd0, 5'd0);           // control byte ignored
        queue_cmd(FUNC_PUT, 8'h1F, 7'd5, 5'd5);           // last control byte ignored
        queue_cmd(FUNC_PUT, CH_BS, 7'd0, 5'd0);           // backspace blanks column 0
        queue_cmd(FUNC_PUT, CH_BS, 7'd0, 5'd0);           // backspace at column 0
        queue_cmd(FUNC_PUT, SPACE_CHAR, 7'd0, 5'd0);      // lowest printable
        queue_cmd(FUNC_PUT, 8'h7F, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, 8'hFF, 7'd0, 5'd0);           // highest byte
        queue_cmd(FUNC_PUT, CH_TAB, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, CH_LF, 7'd0, 5'd0);
        queue_cmd(FUNC_READ, 8'hFF, 7'd1, 5'd0);
        queue_cmd(FUNC_SETCUR, 8'h00, 7'd127, 5'd31);     // clamped to the last cell
        queue_cmd(FUNC_PUT, 8'h5A, 7'd0, 5'd0);           // column wrap into a scroll
        queue_cmd(FUNC_READ, 8'h00, 7'd79, 5'd23);        // written cell moved up
        queue_cmd(FUNC_READ, 8'h00, 7'd127, 5'd31);       // clamped read
        queue_cmd(FUNC_SETCUR, 8'h00, 7'd76, 5'd24);
        queue_cmd(FUNC_PUT, CH_TAB, 7'd0, 5'd0);          // tab past the edge scrolls
        queue_cmd(FUNC_PUT, CH_LF, 7'd0, 5'd0);           // newline on last row scrolls
        queue_cmd(FUNC_SETCUR, 8'h00, 7'd79, 5'd0);
        queue_cmd(FUNC_PUT, 8'h80, 7'd0, 5'd0);           // wrap without scroll
        queue_cmd(FUNC_READ, 8'h00, 7'd79, 5'd0);
        queue_cmd(FUNC_CLEAR, 8'hFF, 7'd127, 5'd31);
        queue_cmd(FUNC_READ, 8'h00, 7'd5, 5'd5);
        wait_for_drain();

        // color per phase: both extremes, two fixed middle values and two random settings
        color_pick[0] = 4'h0;
        color_pick[1] = 4'hF;
        color_pick[2] = 4'($urandom_range(1, 14));
        color_pick[3] = 4'h8;
        color_pick[4] = 4'($urandom_range(0, 15));
        color_pick[5] = 4'h7;

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            // color write while nothing is in flight
            i_cfg_data  <= color_pick[ph];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            // one phase runs with no idling at all
            steady = (ph == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                p = $urandom_range(0, 99);
                if (p < 66)
                    queue_cmd(FUNC_PUT, draw_char(), 7'($urandom), 5'($urandom));
                else if (p < 68)
                    queue_cmd(FUNC_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
                else if (p < 83)
                    queue_cmd(FUNC_SETCUR, 8'($urandom), draw_col(), draw_row());
                else
                    queue_cmd(FUNC_READ, 8'($urandom), draw_col(), draw_row());
            end
            wait_for_drain();
        end

        // room for any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/text_console_cell_writer_unit.sv
hdl/tcw_checker.sv
dv/tb_text_console_cell_writer_unit.sv
